### rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Payload structs, operation and status codes, and the command that the
// controller broadcasts to the row of entry cells.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W   = 3;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_POS   = 3'd4;
   localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd5;

   localparam logic [STAT_W-1:0] STAT_DONE        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INS_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REM_REFUSED = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [VAL_W-1:0] removed_value;
      logic [CNT_W-1:0]        entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic                    shift_up;
      logic                    shift_down;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              take;
      logic [CNT_W-1:0]  entry_count;
   } ctrl_stat_type;

endpackage

### rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one entry of the list
// Holds one entry and, on a shift command, loads the new value, the entry
// of its lower neighbor or the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module pal_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  pal_pkg::cell_cmd_type   cmd,
   input  logic [DATA_WIDTH-1:0]   data_lo,
   input  logic [DATA_WIDTH-1:0]   data_hi,
   output logic [DATA_WIDTH-1:0]   data_out,
   output logic                    at_pos
);
   import pal_pkg::*;

   localparam logic [31:0] CELL_IDX = 32'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  above;

   assign at_pos = (32'(cmd.position) == CELL_IDX);
   assign above  = (32'(cmd.position) < CELL_IDX);

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (at_pos) begin
            data_in = DATA_WIDTH'($unsigned(cmd.value));
         end else if (above) begin
            data_in = data_lo;
         end
      end else if (cmd.shift_down && (at_pos || above)) begin
         data_in = data_hi;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### rtl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl: request decoder and entry counter
// Holds the capacity register and the entry count, checks each request
// and turns it into a shift command for the row of cells.
// ----------------------------------------------------------------------------
module pal_ctrl #(
   parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [pal_pkg::CNT_W-1:0] csr_wr_data,
   input  logic                     accept,
   input  pal_pkg::req_payload_type req,
   output pal_pkg::cell_cmd_type    cmd,
   output pal_pkg::ctrl_stat_type   stat
);
   import pal_pkg::*;

   logic [CNT_W-1:0] cap_ff;
   logic [CNT_W-1:0] cap_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] limit;
   logic             room;
   logic             nonempty;
   logic             ins_ok;
   logic             rem_ok;
   logic [POS_W-1:0] target;

   // A capacity above the number of cells saturates to the cell count.
   assign limit    = (32'(cap_ff) > 32'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;
   assign room     = (count_ff < limit);
   assign nonempty = (count_ff != '0);

   always_comb begin
      ins_ok      = 1'b0;
      rem_ok      = 1'b0;
      target      = '0;
      stat.status = STAT_DONE;
      unique case (req.op)
         OP_INS_FRONT: begin
            ins_ok = room;
         end
         OP_INS_POS: begin
            ins_ok = room && (req.position <= count_ff);
            target = req.position;
         end
         OP_INS_BACK: begin
            ins_ok = room;
            target = count_ff;
         end
         OP_REM_FRONT: begin
            rem_ok = nonempty;
         end
         OP_REM_POS: begin
            rem_ok = (req.position < count_ff);
            target = req.position;
         end
         OP_REM_BACK: begin
            rem_ok = nonempty;
            target = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
      if ((req.op == OP_INS_FRONT || req.op == OP_INS_POS || req.op == OP_INS_BACK)
          && !ins_ok) begin
         stat.status = STAT_INS_REFUSED;
      end
      if ((req.op == OP_REM_FRONT || req.op == OP_REM_POS || req.op == OP_REM_BACK)
          && !rem_ok) begin
         stat.status = STAT_REM_REFUSED;
      end
      stat.take        = rem_ok;
      stat.entry_count = count_ff;
      if (ins_ok) begin
         stat.entry_count = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         stat.entry_count = count_ff - CNT_W'(1);
      end
   end

   assign cmd.shift_up   = accept && ins_ok;
   assign cmd.shift_down = accept && rem_ok;
   assign cmd.position   = target;
   assign cmd.value      = req.value;

   assign count_in = accept ? stat.entry_count : count_ff;
   assign cap_in   = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
   end

endmodule

### rtl/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// positional_array_list_core: ordered list held in a row of entry cells
// Each request inserts at the front, at a position or at the back, or
// removes from the front, at a position or from the back; every request
// returns one response with a status, the removed value and the count.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel and responses leave on the rsp_
// channel, both with valid/ready handshakes. The user must write the
// capacity register via csr_wr_en/csr_wr_data only while no transaction
// is pending; the block does not enforce this. A request is decoded, the
// cells shift up or down in parallel, and an output register holds the
// response, valid in the next cycle. With rsp_ready held high the block
// takes one request every cycle; the single output register sets this
// figure, since the list update itself completes in the accepting cycle.
// When the receiver stalls, the pending response is held and req_ready
// drops until it is taken. Reset empties the list, sets the capacity to
// 16 and drops rsp_valid; the entry cells themselves are not cleared, as
// a cell is only read after it has been written.
// ----------------------------------------------------------------------------
module positional_array_list_core #(
   parameter int DEPTH      = pal_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pal_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pal_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [pal_pkg::CNT_W-1:0] csr_wr_data
);
   import pal_pkg::*;

   cell_cmd_type          cmd;
   ctrl_stat_type         stat;
   logic                  accept;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_hit;
   logic [DATA_WIDTH-1:0] picked;
   logic [VAL_W-1:0]      picked_ext;
   rsp_payload_type       rsp_ff;
   rsp_payload_type       rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   pal_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lo;
      logic [DATA_WIDTH-1:0] hi;
      if (g == 0) begin : g_first
         assign lo = '0;
      end else begin : g_lo
         assign lo = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign hi = cell_data[g];
      end else begin : g_hi
         assign hi = cell_data[g+1];
      end
      pal_cell #(
         .INDEX      (g),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .data_lo  (lo),
         .data_hi  (hi),
         .data_out (cell_data[g]),
         .at_pos   (cell_hit[g])
      );
   end

   // Exactly one cell matches a valid remove position, so an AND-OR picks it.
   always_comb begin
      picked = '0;
      for (int i = 0; i < DEPTH; i++) begin
         picked = picked | (cell_data[i] & {DATA_WIDTH{cell_hit[i]}});
      end
   end

   if (DATA_WIDTH >= VAL_W) begin : g_wide
      assign picked_ext = picked[VAL_W-1:0];
   end else begin : g_narrow
      assign picked_ext = VAL_W'($signed(picked));
   end

   always_comb begin
      rsp_in.status        = stat.status;
      rsp_in.entry_count   = stat.entry_count;
      rsp_in.removed_value = stat.take ? $signed(picked_ext) : '1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for positional_array_list_core
// Drives list operations over the req_ channel and checks every response
// against a behavioral model of the list kept in this bench. It covers edge
// cases, capacity settings, random traffic under several idle and stall
// patterns, and a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEF;
   localparam int LIMIT_CYCLES = 300000;

   // Op codes the block does not define; they must leave the list alone.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   positional_array_list_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Model of the list and its capacity register.
   logic signed [VAL_W-1:0] list_cells [LIST_DEPTH];
   int                      list_len = 0;
   logic [CNT_W-1:0]        capacity_reg = CAP_RESET;

   rsp_payload_type expected_rsp [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int rsp_checked = 0;
   int ins_refused = 0;
   int rem_refused = 0;
   int peak_len = 0;
   int fill_bias = 50;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want,
               cycle_count);
   endtask

   function automatic void insert_cell(input int p, input logic signed [VAL_W-1:0] v);
      for (int i = list_len; i > p; i--)
         list_cells[i] = list_cells[i-1];
      list_cells[p] = v;
      list_len++;
      if (list_len > peak_len)
         peak_len = list_len;
   endfunction

   function automatic logic signed [VAL_W-1:0] remove_cell(input int p);
      logic signed [VAL_W-1:0] v;
      v = list_cells[p];
      for (int i = p; i + 1 < list_len; i++)
         list_cells[i] = list_cells[i+1];
      list_len--;
      return v;
   endfunction

   // Applies one operation to the model list and returns the response it owes.
   function automatic rsp_payload_type predict_list_op(input req_payload_type r);
      rsp_payload_type o;
      int              lim;
      logic            room;
      lim  = (capacity_reg > LIST_DEPTH) ? LIST_DEPTH : int'(capacity_reg);
      room = list_len < lim;
      o.status        = STAT_DONE;
      o.removed_value = -1;
      case (r.op)
         OP_INS_FRONT: begin
            if (room) insert_cell(0, r.value);
            else o.status = STAT_INS_REFUSED;
         end
         OP_INS_POS: begin
            if (room && r.position <= list_len) insert_cell(int'(r.position), r.value);
            else o.status = STAT_INS_REFUSED;
         end
         OP_INS_BACK: begin
            if (room) insert_cell(list_len, r.value);
            else o.status = STAT_INS_REFUSED;
         end
         OP_REM_FRONT: begin
            if (list_len > 0) o.removed_value = remove_cell(0);
            else o.status = STAT_REM_REFUSED;
         end
         OP_REM_POS: begin
            if (r.position < list_len) o.removed_value = remove_cell(int'(r.position));
            else o.status = STAT_REM_REFUSED;
         end
         OP_REM_BACK: begin
            if (list_len > 0) o.removed_value = remove_cell(list_len - 1);
            else o.status = STAT_REM_REFUSED;
         end
         default: ;
      endcase
      if (o.status == STAT_INS_REFUSED) ins_refused++;
      if (o.status == STAT_REM_REFUSED) rem_refused++;
      o.entry_count = CNT_W'(list_len);
      return o;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                               input logic [31:0] val);
      req_payload_type r;
      r.op       = op;
      r.position = POS_W'(pos);
      r.value    = val;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_list_op(r));
      items_sent++;
   endtask

   // Lets every pending response come back, then idles a little before returning.
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input int v);
      settle_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      capacity_reg = CNT_W'(v);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal positions, with an occasional one anywhere in the field.
   function automatic int pick_position(input logic is_insert);
      if ($urandom_range(7) == 0)
         return $urandom_range(31);
      if (is_insert)
         return $urandom_range(list_len);
      return (list_len > 0) ? $urandom_range(list_len - 1) : 0;
   endfunction

   task automatic run_random_traffic(input int n);
      logic [OP_W-1:0] op;
      for (int k = 0; k < n; k++) begin
         // Swing the list between nearly full and nearly empty.
         if (k % 32 == 0)
            fill_bias = ($urandom_range(1) == 0) ? 80 : 20;
         if ($urandom_range(99) < 4)
            op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
         else if ($urandom_range(99) < fill_bias)
            case ($urandom_range(2))
               0: op = OP_INS_FRONT;
               1: op = OP_INS_POS;
               default: op = OP_INS_BACK;
            endcase
         else
            case ($urandom_range(2))
               0: op = OP_REM_FRONT;
               1: op = OP_REM_POS;
               default: op = OP_REM_BACK;
            endcase
         send_request(op, pick_position(op <= OP_INS_BACK), pick_value());
      end
   endtask

   task automatic test_directed_edges();
      send_request(OP_REM_FRONT, 0, 32'h0);
      send_request(OP_REM_BACK, 0, 32'h0);
      send_request(OP_REM_POS, 0, 32'h0);
      send_request(OP_INS_POS, 1, 32'h1234_5678);
      send_request(OP_INS_FRONT, 0, 32'h7FFF_FFFF);
      send_request(OP_INS_BACK, 31, 32'h8000_0000);
      send_request(OP_INS_POS, 1, 32'hFFFF_FFFF);
      send_request(OP_INS_POS, 3, 32'h0000_0000);
      send_request(OP_INS_POS, 31, 32'h5555_AAAA);
      send_request(OP_SPARE_A, 31, 32'hFFFF_FFFF);
      send_request(OP_SPARE_B, 0, 32'h0);
      send_request(OP_REM_POS, 1, 32'h0);
      send_request(OP_REM_POS, 31, 32'h0);
      send_request(OP_REM_POS, 16, 32'h0);
      send_request(OP_REM_FRONT, 0, 32'h0);
      send_request(OP_REM_BACK, 0, 32'h0);
      send_request(OP_REM_BACK, 0, 32'h0);
      send_request(OP_REM_BACK, 0, 32'h0);
      settle_idle();
   endtask

   task automatic test_capacity_limits();
      // A zero capacity refuses every insert.
      write_capacity(0);
      send_request(OP_INS_FRONT, 0, 32'h1);
      send_request(OP_INS_BACK, 0, 32'h2);
      send_request(OP_INS_POS, 0, 32'h3);
      write_capacity(2);
      for (int i = 0; i < 3; i++)
         send_request(OP_INS_BACK, 0, pick_value());
      // Values above the store depth saturate to the depth.
      write_capacity(31);
      while (list_len < LIST_DEPTH)
         send_request(OP_INS_POS, pick_position(1'b1), pick_value());
      send_request(OP_INS_POS, 16, 32'hDEAD_BEEF);
      send_request(OP_INS_FRONT, 0, 32'hDEAD_BEEF);
      // Lowering below the count blocks inserts but removes still work.
      write_capacity(3);
      send_request(OP_INS_BACK, 0, 32'h42);
      send_request(OP_REM_POS, 15, 32'h0);
      send_request(OP_REM_POS, 16, 32'h0);
      send_request(OP_REM_FRONT, 0, 32'h0);
      send_request(OP_INS_FRONT, 0, 32'h43);
      write_capacity(16);
   endtask

   task automatic test_random_no_idle();
      idle_pct  = 0;
      stall_pct = 0;
      run_random_traffic(300);
      settle_idle();
   endtask

   task automatic test_random_sender_gaps();
      write_capacity(31);
      idle_pct  = 80;
      stall_pct = 0;
      run_random_traffic(200);
      settle_idle();
   endtask

   task automatic test_random_receiver_stalls();
      write_capacity(5);
      idle_pct  = 0;
      stall_pct = 80;
      run_random_traffic(200);
      settle_idle();
   endtask

   task automatic test_random_mixed_idle();
      write_capacity(1);
      idle_pct  = 18;
      stall_pct = 18;
      run_random_traffic(80);
      write_capacity(16);
      run_random_traffic(250);
      settle_idle();
   endtask

   task automatic test_backpressure_fill();
      idle_pct  = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_cycles = 80;
      run_random_traffic(40);
      settle_idle();
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_payload), 32'h0);
         end else begin
            rsp_payload_type want;
            want = expected_rsp.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.removed_value !== want.removed_value)
               report_mismatch("removed_value", rsp_payload.removed_value,
                               want.removed_value);
            if (rsp_payload.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_payload.entry_count),
                               32'(want.entry_count));
            rsp_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_capacity_limits();
      test_random_no_idle();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_mixed_idle();
      test_backpressure_fill();

      if (expected_rsp.size() != 0)
         report_mismatch("transactions never returned", expected_rsp.size(), 32'h0);
      $display("Sent %0d requests, checked %0d responses in %0d cycles.",
               items_sent, rsp_checked, cycle_count);
      $display("Refused inserts %0d, refused removes %0d, longest list %0d entries.",
               ins_refused, rem_refused, peak_len);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_core.sv
bench/tb_top.sv
